// ----- rtl/bech32_string_encoder_defines.svh -----
// Assertion helpers for the checker file.
`ifndef BECH32_STRING_ENCODER_DEFINES_SVH
`define BECH32_STRING_ENCODER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define B32_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low
`define B32_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/b32enc_pkg.sv -----
`timescale 1ns / 1ps
package b32enc_pkg;

	// Default limits
	localparam int PREFIX_MAX_DEF = 83;
	localparam int STRING_MAX_DEF = 90;

	// Checksum geometry
	localparam int ACC_W   = 30;
	localparam int SUM_LEN = 6;
	localparam int CNT_W   = 3;
	localparam logic [ACC_W-1:0] ACC_INIT = 30'h0000_0001;

	// Action codes
	localparam logic [1:0] ACT_PREFIX = 2'd0;
	localparam logic [1:0] ACT_VALUE  = 2'd1;
	localparam logic [1:0] ACT_FINISH = 2'd2;

	// Status codes
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_BADCHAR = 3'd1;
	localparam logic [2:0] ST_UPPER   = 3'd2;
	localparam logic [2:0] ST_EMPTY   = 3'd3;
	localparam logic [2:0] ST_PLONG   = 3'd4;
	localparam logic [2:0] ST_SLONG   = 3'd5;
	localparam logic [2:0] ST_BIG     = 3'd6;
	localparam logic [2:0] ST_ORDER   = 3'd7;

	// Separator character '1'
	localparam logic [6:0] SEP_CHAR = 7'h31;

	// Data alphabet, indexed by 5-bit value
	localparam logic [6:0] CHARSET [32] = '{
		7'h71, 7'h70, 7'h7a, 7'h72, 7'h79, 7'h39, 7'h78, 7'h38,
		7'h67, 7'h66, 7'h32, 7'h74, 7'h76, 7'h64, 7'h77, 7'h30,
		7'h73, 7'h33, 7'h6a, 7'h6e, 7'h35, 7'h34, 7'h6b, 7'h68,
		7'h63, 7'h65, 7'h36, 7'h6d, 7'h75, 7'h61, 7'h37, 7'h6c
	};

	// Accumulator operation
	typedef enum logic [2:0] {
		ACC_HOLD,
		ACC_STEP,
		ACC_PREFIX,
		ACC_REPLAY,
		ACC_VALUE,
		ACC_FINAL,
		ACC_SHIFT
	} acc_op_t;

	// Output register load source
	typedef enum logic [2:0] {
		EM_NONE,
		EM_ECHO,
		EM_SEP,
		EM_DATA,
		EM_ERR,
		EM_SUM
	} emit_t;

	// Controller to datapath commands
	typedef struct packed {
		logic    latch;
		acc_op_t acc_op;
		logic    store_low;
		logic    set_err;
		logic    set_data;
		logic    rd_start;
		logic    rd_next;
		logic    cnt_clr;
		logic    cnt_inc;
		emit_t   emit;
		logic    clear;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic [1:0] act;
		logic       chk_fail;
		logic       err_set;
		logic       in_data;
		logic       no_prefix;
		logic       rd_done;
		logic       cnt_last;
		logic       out_free;
	} sts_t;

	// One BCH polymod step: shift by one symbol and fold the top bits back
	function automatic logic [ACC_W-1:0] bch_step(input logic [ACC_W-1:0] c);
		logic [4:0]       top;
		logic [ACC_W-1:0] r;
		top = c[29:25];
		r   = {c[24:0], 5'b0};
		if (top[0]) r = r ^ 30'h3b6a57b2;
		if (top[1]) r = r ^ 30'h26508e6d;
		if (top[2]) r = r ^ 30'h1ea119fa;
		if (top[3]) r = r ^ 30'h3d4233dd;
		if (top[4]) r = r ^ 30'h2a1462b3;
		return r;
	endfunction

endpackage

// ----- rtl/b32enc_ram.sv -----
`timescale 1ns / 1ps
module b32enc_ram #(
	parameter int WIDTH = 5,
	parameter int DEPTH = 83,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/b32enc_dp.sv -----
`timescale 1ns / 1ps
module b32enc_dp #(
	parameter int PREFIX_MAX = b32enc_pkg::PREFIX_MAX_DEF,
	parameter int STRING_MAX = b32enc_pkg::STRING_MAX_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [1:0]        in_action,
	input  logic [7:0]        in_symbol,
	input  b32enc_pkg::cmd_t  cmd,
	output b32enc_pkg::sts_t  sts,
	input  logic              out_ready,
	output logic              out_valid,
	output logic [6:0]        out_char,
	output logic [2:0]        out_status,
	output logic              out_is_last
);

	localparam int PCW = $clog2(PREFIX_MAX + 1);
	localparam int SCW = $clog2(STRING_MAX + 1);
	localparam int AW  = (PREFIX_MAX > 1) ? $clog2(PREFIX_MAX) : 1;
	localparam int LW  = $clog2(PREFIX_MAX + STRING_MAX + 2 + b32enc_pkg::SUM_LEN + 1);
	localparam logic [LW-1:0]  OVH   = LW'(2 + b32enc_pkg::SUM_LEN);
	localparam logic [LW-1:0]  LIMIT = LW'(STRING_MAX);
	localparam logic [PCW-1:0] PMAX  = PCW'(PREFIX_MAX);
	localparam logic [b32enc_pkg::CNT_W-1:0] CNT_END = b32enc_pkg::CNT_W'(b32enc_pkg::SUM_LEN - 1);

	logic [1:0]                     act_q;
	logic [7:0]                     sym_q;
	logic [b32enc_pkg::ACC_W-1:0]   acc_q;
	logic [b32enc_pkg::ACC_W-1:0]   acc_step;
	logic [PCW-1:0]                 pcount_q;
	logic [SCW-1:0]                 vcount_q;
	logic                           in_data_q;
	logic [2:0]                     err_q;
	logic [PCW-1:0]                 ridx_q;
	logic [b32enc_pkg::CNT_W-1:0]   cnt_q;
	logic                           cnt_last;
	logic [AW-1:0]                  raddr;
	logic [4:0]                     rd_data;
	logic [2:0]                     chk_code;
	logic [LW-1:0]                  plen;
	logic [LW-1:0]                  vlen;
	logic                           out_valid_q;
	logic [6:0]                     out_char_q;
	logic [2:0]                     out_status_q;
	logic                           out_last_q;

	assign cnt_last = (cnt_q == CNT_END);
	assign plen     = LW'(pcount_q);
	assign vlen     = LW'(vcount_q);
	assign acc_step = b32enc_pkg::bch_step(acc_q);

	// Hold the accepted item
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			act_q <= in_action;
			sym_q <= in_symbol;
		end
	end

	// Check the held item against the string state, in priority order
	always_comb begin
		chk_code = b32enc_pkg::ST_OK;
		if (act_q == b32enc_pkg::ACT_PREFIX) begin
			if (in_data_q) begin
				chk_code = b32enc_pkg::ST_ORDER;
			end else if (sym_q < 8'h21 || sym_q > 8'h7e) begin
				chk_code = b32enc_pkg::ST_BADCHAR;
			end else if (sym_q >= 8'h41 && sym_q <= 8'h5a) begin
				chk_code = b32enc_pkg::ST_UPPER;
			end else if (pcount_q >= PMAX) begin
				chk_code = b32enc_pkg::ST_PLONG;
			end else if (plen + OVH > LIMIT) begin
				chk_code = b32enc_pkg::ST_SLONG;
			end
		end else if (act_q == b32enc_pkg::ACT_VALUE) begin
			if (pcount_q == '0) begin
				chk_code = b32enc_pkg::ST_EMPTY;
			end else if (plen + vlen + OVH > LIMIT) begin
				chk_code = b32enc_pkg::ST_SLONG;
			end else if (sym_q[7:5] != 3'b000) begin
				chk_code = b32enc_pkg::ST_BIG;
			end
		end
	end

	// Checksum accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= b32enc_pkg::ACC_INIT;
		end else if (cmd.clear) begin
			acc_q <= b32enc_pkg::ACC_INIT;
		end else begin
			case (cmd.acc_op)
				b32enc_pkg::ACC_STEP:   acc_q <= acc_step;
				b32enc_pkg::ACC_PREFIX: acc_q <= acc_step ^ b32enc_pkg::ACC_W'(sym_q[7:5]);
				b32enc_pkg::ACC_REPLAY: acc_q <= acc_step ^ b32enc_pkg::ACC_W'(rd_data);
				b32enc_pkg::ACC_VALUE:  acc_q <= acc_step ^ b32enc_pkg::ACC_W'(sym_q[4:0]);
				b32enc_pkg::ACC_FINAL:  acc_q <= acc_step ^ b32enc_pkg::ACC_W'(cnt_last);
				b32enc_pkg::ACC_SHIFT:  acc_q <= {acc_q[24:0], 5'b0};
				default:                acc_q <= acc_q;
			endcase
		end
	end

	// String state: counts, phase and sticky error
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcount_q  <= '0;
			vcount_q  <= '0;
			in_data_q <= 1'b0;
			err_q     <= b32enc_pkg::ST_OK;
		end else if (cmd.clear) begin
			pcount_q  <= '0;
			vcount_q  <= '0;
			in_data_q <= 1'b0;
			err_q     <= b32enc_pkg::ST_OK;
		end else begin
			if (cmd.store_low) begin
				pcount_q <= pcount_q + PCW'(1);
			end
			if (cmd.acc_op == b32enc_pkg::ACC_VALUE) begin
				vcount_q <= vcount_q + SCW'(1);
			end
			if (cmd.set_data) begin
				in_data_q <= 1'b1;
			end
			if (cmd.set_err) begin
				err_q <= chk_code;
			end
		end
	end

	// Replay read index and checksum symbol counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ridx_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (cmd.rd_start) begin
				ridx_q <= PCW'(1);
			end else if (cmd.rd_next) begin
				ridx_q <= ridx_q + PCW'(1);
			end
			if (cmd.cnt_clr) begin
				cnt_q <= '0;
			end else if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + b32enc_pkg::CNT_W'(1);
			end
		end
	end

	// Prefix low-bit store
	assign raddr = cmd.rd_start ? '0 : ridx_q[AW-1:0];

	b32enc_ram #(
		.WIDTH (5),
		.DEPTH (PREFIX_MAX)
	) u_low_ram (
		.clk   (clk),
		.we    (cmd.store_low),
		.waddr (pcount_q[AW-1:0]),
		.wdata (sym_q[4:0]),
		.raddr (raddr),
		.rdata (rd_data)
	);

	// Output register: load on emit, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit != b32enc_pkg::EM_NONE) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.emit)
			b32enc_pkg::EM_ECHO: begin
				out_char_q   <= sym_q[6:0];
				out_status_q <= b32enc_pkg::ST_OK;
				out_last_q   <= 1'b0;
			end
			b32enc_pkg::EM_SEP: begin
				out_char_q   <= b32enc_pkg::SEP_CHAR;
				out_status_q <= b32enc_pkg::ST_OK;
				out_last_q   <= 1'b0;
			end
			b32enc_pkg::EM_DATA: begin
				out_char_q   <= b32enc_pkg::CHARSET[sym_q[4:0]];
				out_status_q <= b32enc_pkg::ST_OK;
				out_last_q   <= 1'b0;
			end
			b32enc_pkg::EM_ERR: begin
				out_char_q   <= 7'h00;
				out_status_q <= (err_q != b32enc_pkg::ST_OK) ? err_q : b32enc_pkg::ST_EMPTY;
				out_last_q   <= 1'b1;
			end
			b32enc_pkg::EM_SUM: begin
				out_char_q   <= b32enc_pkg::CHARSET[acc_q[29:25]];
				out_status_q <= b32enc_pkg::ST_OK;
				out_last_q   <= cnt_last;
			end
			default: begin
				out_char_q   <= out_char_q;
				out_status_q <= out_status_q;
				out_last_q   <= out_last_q;
			end
		endcase
	end

	assign out_valid   = out_valid_q;
	assign out_char    = out_char_q;
	assign out_status  = out_status_q;
	assign out_is_last = out_last_q;

	// Status to the controller
	assign sts.act       = act_q;
	assign sts.chk_fail  = (chk_code != b32enc_pkg::ST_OK);
	assign sts.err_set   = (err_q != b32enc_pkg::ST_OK);
	assign sts.in_data   = in_data_q;
	assign sts.no_prefix = (pcount_q == '0);
	assign sts.rd_done   = (ridx_q == pcount_q);
	assign sts.cnt_last  = cnt_last;
	assign sts.out_free  = !out_valid_q || out_ready;

endmodule

// ----- rtl/b32enc_ctrl.sv -----
`timescale 1ns / 1ps
module b32enc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  b32enc_pkg::sts_t sts,
	output b32enc_pkg::cmd_t cmd
);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_CHECK = 8'b0000_0010,
		S_RPL0  = 8'b0000_0100,
		S_RPL   = 8'b0000_1000,
		S_SEP   = 8'b0001_0000,
		S_DATA  = 8'b0010_0000,
		S_FIN   = 8'b0100_0000,
		S_SUM   = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		cmd        = '0;
		cmd.acc_op = b32enc_pkg::ACC_HOLD;
		cmd.emit   = b32enc_pkg::EM_NONE;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_CHECK;
				end
			end
			S_CHECK: begin
				unique case (sts.act)
					b32enc_pkg::ACT_PREFIX: begin
						if (sts.err_set) begin
							state_d = S_IDLE;
						end else if (sts.chk_fail) begin
							cmd.set_err = 1'b1;
							state_d     = S_IDLE;
						end else if (sts.out_free) begin
							cmd.acc_op    = b32enc_pkg::ACC_PREFIX;
							cmd.store_low = 1'b1;
							cmd.emit      = b32enc_pkg::EM_ECHO;
							state_d       = S_IDLE;
						end
					end
					b32enc_pkg::ACT_VALUE: begin
						if (sts.err_set) begin
							state_d = S_IDLE;
						end else if (sts.chk_fail) begin
							cmd.set_err = 1'b1;
							state_d     = S_IDLE;
						end else if (!sts.in_data) begin
							state_d = S_RPL0;
						end else begin
							state_d = S_DATA;
						end
					end
					b32enc_pkg::ACT_FINISH: begin
						if (sts.err_set || sts.no_prefix) begin
							if (sts.out_free) begin
								cmd.emit  = b32enc_pkg::EM_ERR;
								cmd.clear = 1'b1;
								state_d   = S_IDLE;
							end
						end else if (!sts.in_data) begin
							state_d = S_RPL0;
						end else begin
							cmd.cnt_clr = 1'b1;
							state_d     = S_FIN;
						end
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			// Separator position: one bare step, start reading the prefix
			S_RPL0: begin
				cmd.acc_op   = b32enc_pkg::ACC_STEP;
				cmd.rd_start = 1'b1;
				state_d      = S_RPL;
			end
			// Fold one stored low part per cycle
			S_RPL: begin
				cmd.acc_op = b32enc_pkg::ACC_REPLAY;
				if (sts.rd_done) begin
					state_d = S_SEP;
				end else begin
					cmd.rd_next = 1'b1;
				end
			end
			S_SEP: begin
				if (sts.out_free) begin
					cmd.emit     = b32enc_pkg::EM_SEP;
					cmd.set_data = 1'b1;
					if (sts.act == b32enc_pkg::ACT_VALUE) begin
						state_d = S_DATA;
					end else begin
						cmd.cnt_clr = 1'b1;
						state_d     = S_FIN;
					end
				end
			end
			S_DATA: begin
				if (sts.out_free) begin
					cmd.acc_op = b32enc_pkg::ACC_VALUE;
					cmd.emit   = b32enc_pkg::EM_DATA;
					state_d    = S_IDLE;
				end
			end
			// Six padding steps, final constant folded on the last
			S_FIN: begin
				cmd.acc_op = b32enc_pkg::ACC_FINAL;
				if (sts.cnt_last) begin
					cmd.cnt_clr = 1'b1;
					state_d     = S_SUM;
				end else begin
					cmd.cnt_inc = 1'b1;
				end
			end
			// Emit checksum symbols from the top of the accumulator
			S_SUM: begin
				if (sts.out_free) begin
					cmd.emit   = b32enc_pkg::EM_SUM;
					cmd.acc_op = b32enc_pkg::ACC_SHIFT;
					if (sts.cnt_last) begin
						cmd.clear = 1'b1;
						state_d   = S_IDLE;
					end else begin
						cmd.cnt_inc = 1'b1;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ----- rtl/bech32_string_encoder.sv -----
// Streaming bech32 string encoder. Feed the human-readable prefix one ASCII
// byte at a time (action 0), then 5-bit data values (action 1), then finish
// (action 2); the block echoes the prefix, emits the separator and one
// charset character per value, and ends with six checksum characters, the
// last flagged is_last. Any error is sticky and reported by a single
// result with out_char 0 and the error status at finish. Items are taken one
// at a time: a prefix character is checked and echoed, a data value checked
// and encoded; the first data value (or a finish with no data) replays the
// stored prefix characters through the checksum, and a finish runs padding
// steps and emits the checksum, all extended by output stalls. The pace is
// set by the single checksum step unit, one step per cycle unless an output
// stall holds it, and by the one read port of the prefix store during replay. A
// result waiting in the output register does not block the next input transfer.
`timescale 1ns / 1ps
module bech32_string_encoder #(
	parameter int PREFIX_MAX = b32enc_pkg::PREFIX_MAX_DEF,
	parameter int STRING_MAX = b32enc_pkg::STRING_MAX_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] action,
	input  logic [7:0] symbol,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [6:0] out_char,
	output logic [2:0] status,
	output logic       is_last
);

	b32enc_pkg::cmd_t cmd;
	b32enc_pkg::sts_t sts;

	b32enc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	b32enc_dp #(
		.PREFIX_MAX (PREFIX_MAX),
		.STRING_MAX (STRING_MAX)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_action   (action),
		.in_symbol   (symbol),
		.cmd         (cmd),
		.sts         (sts),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.out_char    (out_char),
		.out_status  (status),
		.out_is_last (is_last)
	);

endmodule

// ----- rtl/b32enc_checker.sv -----
`timescale 1ns / 1ps
`include "bech32_string_encoder_defines.svh"
module b32enc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [6:0] out_char,
	input logic [2:0] status,
	input logic       is_last
);

	// Hold a stalled result
	`B32_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_char) && $stable(status) && $stable(is_last), "stalled result changed")

	// One item at a time: no transfer right after a transfer
	`B32_ASSERT_NEXT(a_in_one, in_valid && in_ready, !in_ready, "input taken in back-to-back cycles")

	// An error result is the last one and carries no character
	`B32_ASSERT_NOW(a_err_form, out_valid && status != b32enc_pkg::ST_OK, out_char == 7'h00 && is_last, "malformed error result")

	// A good result always carries a printable character
	`B32_ASSERT_NOW(a_ok_char, out_valid && status == b32enc_pkg::ST_OK, out_char > 7'h20 && out_char < 7'h7f, "bad character in result")

endmodule

bind bech32_string_encoder b32enc_checker u_b32enc_checker (.*);

// ----- tb/bech32_string_encoder_test.sv -----
`timescale 1ns / 1ps
module bech32_string_encoder_test;

	// Item that is neither prefix, value nor finish
	localparam logic [1:0] ACT_NONE = 2'd3;
	localparam logic [6:0] SEP = 7'h31;
	localparam logic [8*32-1:0] ALPHABET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

	typedef struct packed {
		logic [6:0] ch;
		logic [2:0] st;
		logic       last;
	} enc_char_t;

	typedef struct packed {
		logic [1:0] act;
		logic [7:0] sym;
		logic       typed;
		logic       has_res;
		enc_char_t  res;
	} drive_row_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [1:0] action;
	logic [7:0] symbol;
	logic       out_valid;
	logic       out_ready;
	logic [6:0] out_char;
	logic [2:0] status;
	logic       is_last;

	// Encoder state as seen by the predictor
	logic [29:0] sum_acc;
	logic [4:0]  hrp_low [0:b32enc_pkg::PREFIX_MAX_DEF-1];
	int          hrp_len;
	int          value_len;
	logic        data_phase;
	logic [2:0]  err_code;

	enc_char_t exp_chars [$];
	enc_char_t step_chars [$];
	int        mismatches = 0;
	int        results_seen = 0;
	int        items_sent = 0;
	bit        no_gaps;

	// Directed rows; typed rows carry their result, the rest go through the predictor
	drive_row_t dir_rows [0:25] = '{
		'{b32enc_pkg::ACT_FINISH, 8'h00, 1'b1, 1'b1, '{7'h00, b32enc_pkg::ST_EMPTY, 1'b1}},
		'{b32enc_pkg::ACT_VALUE,  8'h00, 1'b1, 1'b0, '0},
		'{b32enc_pkg::ACT_FINISH, 8'hff, 1'b1, 1'b1, '{7'h00, b32enc_pkg::ST_EMPTY, 1'b1}},
		'{b32enc_pkg::ACT_PREFIX, 8'h61, 1'b1, 1'b1, '{7'h61, b32enc_pkg::ST_OK, 1'b0}},
		'{b32enc_pkg::ACT_PREFIX, 8'h21, 1'b1, 1'b1, '{7'h21, b32enc_pkg::ST_OK, 1'b0}},
		'{b32enc_pkg::ACT_PREFIX, 8'h7e, 1'b1, 1'b1, '{7'h7e, b32enc_pkg::ST_OK, 1'b0}},
		'{b32enc_pkg::ACT_VALUE,  8'h00, 1'b0, 1'b0, '0},
		'{b32enc_pkg::ACT_VALUE,  8'h1f, 1'b1, 1'b1, '{7'h6c, b32enc_pkg::ST_OK, 1'b0}},
		'{b32enc_pkg::ACT_FINISH, 8'h00, 1'b0, 1'b0, '0},
		'{b32enc_pkg::ACT_PREFIX, 8'h62, 1'b1, 1'b1, '{7'h62, b32enc_pkg::ST_OK, 1'b0}},
		'{b32enc_pkg::ACT_FINISH, 8'h00, 1'b0, 1'b0, '0},
		'{b32enc_pkg::ACT_PREFIX, 8'h20, 1'b1, 1'b0, '0},
		'{b32enc_pkg::ACT_FINISH, 8'h00, 1'b1, 1'b1, '{7'h00, b32enc_pkg::ST_BADCHAR, 1'b1}},
		'{b32enc_pkg::ACT_PREFIX, 8'h5a, 1'b1, 1'b0, '0},
		'{b32enc_pkg::ACT_FINISH, 8'h00, 1'b1, 1'b1, '{7'h00, b32enc_pkg::ST_UPPER, 1'b1}},
		'{b32enc_pkg::ACT_PREFIX, 8'hff, 1'b1, 1'b0, '0},
		'{b32enc_pkg::ACT_PREFIX, 8'h41, 1'b1, 1'b0, '0},
		'{b32enc_pkg::ACT_FINISH, 8'h00, 1'b1, 1'b1, '{7'h00, b32enc_pkg::ST_BADCHAR, 1'b1}},
		'{b32enc_pkg::ACT_PREFIX, 8'h78, 1'b1, 1'b1, '{7'h78, b32enc_pkg::ST_OK, 1'b0}},
		'{b32enc_pkg::ACT_VALUE,  8'h20, 1'b1, 1'b0, '0},
		'{b32enc_pkg::ACT_FINISH, 8'h00, 1'b1, 1'b1, '{7'h00, b32enc_pkg::ST_BIG, 1'b1}},
		'{b32enc_pkg::ACT_PREFIX, 8'h7a, 1'b1, 1'b1, '{7'h7a, b32enc_pkg::ST_OK, 1'b0}},
		'{b32enc_pkg::ACT_VALUE,  8'h05, 1'b0, 1'b0, '0},
		'{b32enc_pkg::ACT_PREFIX, 8'h79, 1'b1, 1'b0, '0},
		'{ACT_NONE,               8'hff, 1'b1, 1'b0, '0},
		'{b32enc_pkg::ACT_FINISH, 8'h00, 1'b1, 1'b1, '{7'h00, b32enc_pkg::ST_ORDER, 1'b1}}
	};

	bech32_string_encoder u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.symbol    (symbol),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_char  (out_char),
		.status    (status),
		.is_last   (is_last)
	);

	always #4 clk = ~clk;

	// One BCH step of the 30-bit checksum
	function automatic logic [29:0] polymod_step(input logic [29:0] c);
		logic [29:0] r;
		r = {c[24:0], 5'b0};
		if (c[25]) r ^= 30'h3b6a57b2;
		if (c[26]) r ^= 30'h26508e6d;
		if (c[27]) r ^= 30'h1ea119fa;
		if (c[28]) r ^= 30'h3d4233dd;
		if (c[29]) r ^= 30'h2a1462b3;
		return r;
	endfunction

	function automatic logic [6:0] alpha_char(input logic [4:0] idx);
		return ALPHABET[8*(31-idx) +: 7];
	endfunction

	function automatic void add_char(input logic [6:0] ch, input logic [2:0] st,
			input logic last);
		enc_char_t c;
		c.ch = ch;
		c.st = st;
		c.last = last;
		step_chars.push_back(c);
	endfunction

	function automatic void clear_string();
		sum_acc = 30'd1;
		hrp_len = 0;
		value_len = 0;
		data_phase = 1'b0;
		err_code = b32enc_pkg::ST_OK;
	endfunction

	// Fold the stored low bits of the prefix in and emit the separator
	function automatic void open_data();
		sum_acc = polymod_step(sum_acc);
		for (int i = 0; i < hrp_len; i++)
			sum_acc = polymod_step(sum_acc) ^ {25'b0, hrp_low[i]};
		data_phase = 1'b1;
		add_char(SEP, b32enc_pkg::ST_OK, 1'b0);
	endfunction

	// Characters one input item produces, left in step_chars
	function automatic void encode_symbol(input logic [1:0] act, input logic [7:0] sym);
		step_chars.delete();
		if (act == b32enc_pkg::ACT_PREFIX) begin
			if (err_code != b32enc_pkg::ST_OK) return;
			if (data_phase) err_code = b32enc_pkg::ST_ORDER;
			else if (sym < 8'h21 || sym > 8'h7e) err_code = b32enc_pkg::ST_BADCHAR;
			else if (sym >= 8'h41 && sym <= 8'h5a) err_code = b32enc_pkg::ST_UPPER;
			else if (hrp_len >= b32enc_pkg::PREFIX_MAX_DEF) err_code = b32enc_pkg::ST_PLONG;
			else if (hrp_len + 8 > b32enc_pkg::STRING_MAX_DEF) err_code = b32enc_pkg::ST_SLONG;
			else begin
				sum_acc = polymod_step(sum_acc) ^ {27'b0, sym[7:5]};
				hrp_low[hrp_len] = sym[4:0];
				hrp_len++;
				add_char(sym[6:0], b32enc_pkg::ST_OK, 1'b0);
			end
		end else if (act == b32enc_pkg::ACT_VALUE) begin
			if (err_code != b32enc_pkg::ST_OK) return;
			if (hrp_len == 0) err_code = b32enc_pkg::ST_EMPTY;
			else if (hrp_len + value_len + 8 > b32enc_pkg::STRING_MAX_DEF)
				err_code = b32enc_pkg::ST_SLONG;
			else if (sym >= 8'd32) err_code = b32enc_pkg::ST_BIG;
			else begin
				if (!data_phase) open_data();
				sum_acc = polymod_step(sum_acc) ^ {25'b0, sym[4:0]};
				value_len++;
				add_char(alpha_char(sym[4:0]), b32enc_pkg::ST_OK, 1'b0);
			end
		end else if (act == b32enc_pkg::ACT_FINISH) begin
			if (err_code == b32enc_pkg::ST_OK && hrp_len == 0) err_code = b32enc_pkg::ST_EMPTY;
			if (err_code != b32enc_pkg::ST_OK) begin
				add_char(7'h00, err_code, 1'b1);
			end else begin
				if (!data_phase) open_data();
				repeat (6) sum_acc = polymod_step(sum_acc);
				sum_acc ^= 30'd1;
				for (int i = 0; i < 6; i++)
					add_char(alpha_char(sum_acc[25-5*i +: 5]), b32enc_pkg::ST_OK, i == 5);
			end
			clear_string();
		end
	endfunction

	// Mostly back to back, some short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Printable, not uppercase
	function automatic logic [7:0] hrp_byte();
		int r;
		r = $urandom_range(8'h21, 8'h7e - 26);
		if (r >= 8'h41) r += 26;
		return 8'(r);
	endfunction

	// Offer one item, hold it until the transfer, then queue what it should produce
	task automatic send_item(input drive_row_t row);
		int gap;
		gap = no_gaps ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= row.act;
		symbol <= row.sym;
		do @(posedge clk); while (in_ready !== 1'b1);
		if (row.act != ACT_NONE) items_sent++;
		encode_symbol(row.act, row.sym);
		if (row.typed) begin
			if (row.has_res) exp_chars.push_back(row.res);
		end else begin
			foreach (step_chars[i]) exp_chars.push_back(step_chars[i]);
		end
	endtask

	task automatic send(input logic [1:0] act, input logic [7:0] sym);
		drive_row_t row;
		row = '0;
		row.act = act;
		row.sym = sym;
		send_item(row);
	endtask

	// Prefix, values and finish; bad_at places one extra item before that position
	task automatic send_string(input int plen, input int nval, input int bad_at,
			input logic [1:0] bad_act, input logic [7:0] bad_sym);
		for (int k = 0; k <= plen + nval; k++) begin
			if (k == bad_at) send(bad_act, bad_sym);
			if (k < plen) send(b32enc_pkg::ACT_PREFIX, hrp_byte());
			else if (k < plen + nval) send(b32enc_pkg::ACT_VALUE, 8'($urandom_range(0, 31)));
		end
		send(b32enc_pkg::ACT_FINISH, 8'($urandom_range(0, 255)));
	endtask

	// Stimulus
	initial begin
		int kind;
		int plen;
		int nval;
		in_valid <= 1'b0;
		action <= b32enc_pkg::ACT_PREFIX;
		symbol <= 8'h00;
		arst_n <= 1'b0;
		no_gaps = 1'b0;
		clear_string();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[r]) send_item(dir_rows[r]);

		// One prefix too many; then a long prefix and the longest string, maybe one value over
		send_string(b32enc_pkg::PREFIX_MAX_DEF, 1, b32enc_pkg::PREFIX_MAX_DEF,
			b32enc_pkg::ACT_PREFIX, hrp_byte());
		plen = $urandom_range(60, 82);
		nval = b32enc_pkg::STRING_MAX_DEF - 7 - plen;
		send_string(plen, nval, ($urandom_range(0, 1) == 1) ? plen + nval : -1,
			b32enc_pkg::ACT_VALUE, 8'($urandom_range(0, 31)));

		// Random strings: mostly well formed, some broken, some noise
		while (items_sent < 270) begin
			no_gaps = ($urandom_range(0, 3) == 0);
			kind = $urandom_range(0, 99);
			if (kind < 60) begin
				send_string($urandom_range(1, 6), $urandom_range(0, 12), -1, ACT_NONE, 8'h00);
			end else if (kind < 66) begin
				send_string($urandom_range(1, 20), $urandom_range(0, 40), -1, ACT_NONE, 8'h00);
			end else if (kind < 86) begin
				plen = $urandom_range(1, 5);
				nval = $urandom_range(0, 8);
				send_string(plen, nval, $urandom_range(0, plen + nval),
					2'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
			end else begin
				repeat ($urandom_range(1, 6))
					send(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
				send(b32enc_pkg::ACT_FINISH, 8'($urandom_range(0, 255)));
			end
		end
		in_valid <= 1'b0;

		// Drain, then give the block time to show anything extra
		while (exp_chars.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (mismatches == 0)
			$display("bech32_string_encoder_test: clean");
		else
			$display("bech32_string_encoder_test: errors");
		$finish;
	end

	// Output side: random stalls, one long hold-off to back the block up
	initial begin
		int n;
		bit squeezed;
		squeezed = 1'b0;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!squeezed && results_seen >= 40) begin
				squeezed = 1'b1;
				out_ready <= 1'b0;
				repeat (400) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 24)) @(posedge clk);
			n = pick_gap();
			if (n > 0) begin
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
		end
	end

	// Compare each output transfer with the oldest expected character
	always @(posedge clk) begin
		enc_char_t want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
			results_seen++;
			if (exp_chars.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected result: char %02h status %0d last %0d",
						out_char, status, is_last);
				mismatches++;
			end else begin
				want = exp_chars.pop_front();
				if (want.ch !== out_char || want.st !== status || want.last !== is_last) begin
					if (mismatches < 10)
						$display({"mismatch: expected char %02h status %0d last %0d,",
							" got char %02h status %0d last %0d"},
							want.ch, want.st, want.last, out_char, status, is_last);
					mismatches++;
				end
			end
		end
	end

	// Hard stop if the block hangs
	initial begin
		#10_000_000;
		$display("bech32_string_encoder_test: errors");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/b32enc_pkg.sv
rtl/b32enc_ram.sv
rtl/b32enc_dp.sv
rtl/b32enc_ctrl.sv
rtl/bech32_string_encoder.sv
rtl/b32enc_checker.sv
tb/bech32_string_encoder_test.sv
